@@ src/hfmt_pkg.sv @@
// Shared types, constants and helpers for the hex float text formatter.
package hfmt_pkg;

  localparam int MAG_W         = 63;
  localparam int FRAC_W        = 52;
  localparam int EXP_W         = 11;
  localparam int EXP_BIAS      = 1023;
  localparam int SUBN_EXP_MAG  = 1022;
  localparam int FRAC_NIBBLES  = 13;
  localparam int MAX_PRECISION = 48;
  localparam int PREC_W        = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 8;
  localparam int DEC_DIGITS    = 4;
  localparam int BCD_W         = 4 * DEC_DIGITS;
  localparam int NDIG_W        = 3;
  localparam int LEN_W         = 7;
  // x / 10 == (x * 205) >> 11 for x below 1029
  localparam int RECIP_10      = 205;
  localparam int RECIP_SHIFT   = 11;
  localparam int PROD_W        = 19;
  localparam int QUOT_W        = 7;

  localparam logic [7:0] ASC_NUL     = 8'h00;
  localparam logic [7:0] ASC_SPACE   = 8'h20;
  localparam logic [7:0] ASC_PLUS    = 8'h2B;
  localparam logic [7:0] ASC_MINUS   = 8'h2D;
  localparam logic [7:0] ASC_POINT   = 8'h2E;
  localparam logic [7:0] ASC_ZERO    = 8'h30;
  localparam logic [7:0] ASC_UPPER_A = 8'h41;
  localparam logic [7:0] ASC_UPPER_P = 8'h50;
  localparam logic [7:0] ASC_UPPER_X = 8'h58;
  localparam logic [7:0] ASC_LOWER_A = 8'h61;
  localparam logic [7:0] ASC_LOWER_P = 8'h70;
  localparam logic [7:0] ASC_LOWER_X = 8'h78;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRECISION       = 3'd0,
    REG_UPPER_CASE      = 3'd1,
    REG_FORCE_POINT     = 3'd2,
    REG_PLUS_SIGN       = 3'd3,
    REG_SPACE_SIGN      = 3'd4,
    REG_ROUND_MODE      = 3'd5,
    REG_BUFFER_CAPACITY = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RM_NEAREST_EVEN = 2'd0,
    RM_TO_ZERO      = 2'd1,
    RM_TO_PLUS      = 2'd2,
    RM_TO_MINUS     = 2'd3
  } round_mode_t;

  typedef enum logic [3:0] {
    SEL_SIGN      = 4'd0,
    SEL_ZERO      = 4'd1,
    SEL_X         = 4'd2,
    SEL_LEAD      = 4'd3,
    SEL_POINT     = 4'd4,
    SEL_FRAC      = 4'd5,
    SEL_PAD       = 4'd6,
    SEL_EXP_MARK  = 4'd7,
    SEL_EXP_SIGN  = 4'd8,
    SEL_EXP_DIGIT = 4'd9,
    SEL_FAIL      = 4'd10
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      analyze;
    logic      round_en;
    logic      digit_step;
    logic      check;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic              emit_ok;
    logic              has_sign;
    logic              has_point;
    logic [PREC_W-1:0] prec;
    logic [NDIG_W-1:0] ndig;
    logic              too_small;
  } dp_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? ASC_UPPER_A : ASC_LOWER_A;
    if (nib < 4'd10) return ASC_ZERO + {4'b0000, nib};
    else return base + {4'b0000, nib} - 8'd10;
  endfunction

endpackage

@@ src/hfmt_if.sv @@
// Word channel interfaces: input value channel and output character channel.
interface hfmt_in_if;
  logic                        valid;
  logic                        ready;
  logic [hfmt_pkg::MAG_W-1:0]  magnitude_bits;
  logic                        negative;

  modport source (output valid, output magnitude_bits, output negative, input ready);
  modport sink (input valid, input magnitude_bits, input negative, output ready);
endinterface

interface hfmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       status;

  modport source (output valid, output character, output last, output status, input ready);
  modport sink (input valid, input character, input last, input status, output ready);
endinterface

@@ src/hfmt_ctrl.sv @@
// Controller: sequences analysis, rounding, exponent digits and character emission.
module hfmt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hfmt_pkg::dp_sts_t  sts,
  output hfmt_pkg::dp_cmd_t  cmd
);
  import hfmt_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE      = 16'h0001,
    ST_ANALYZE   = 16'h0002,
    ST_ROUND     = 16'h0004,
    ST_DIGIT     = 16'h0008,
    ST_CHECK     = 16'h0010,
    ST_SIGN      = 16'h0020,
    ST_ZERO      = 16'h0040,
    ST_X         = 16'h0080,
    ST_LEAD      = 16'h0100,
    ST_POINT     = 16'h0200,
    ST_FRAC      = 16'h0400,
    ST_PAD       = 16'h0800,
    ST_EXP_MARK  = 16'h1000,
    ST_EXP_SIGN  = 16'h2000,
    ST_EXP_DIGIT = 16'h4000,
    ST_FAIL      = 16'h8000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PREC_W-1:0] rem_r, rem_nxt;
  logic [3:0]        fcnt_r, fcnt_nxt;
  logic [NDIG_W-1:0] ecnt_r, ecnt_nxt;
  logic [1:0]        dcnt_r, dcnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    fcnt_nxt  = fcnt_r;
    ecnt_nxt  = ecnt_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    cmd.sel   = SEL_ZERO;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ANALYZE;
        end
      end
      ST_ANALYZE: begin
        cmd.analyze = 1'b1;
        state_nxt   = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd.digit_step = 1'b1;
        dcnt_nxt       = dcnt_r + 2'd1;
        if (dcnt_r == 2'(DEC_DIGITS - 1)) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.too_small) state_nxt = ST_FAIL;
        else if (sts.has_sign) state_nxt = ST_SIGN;
        else state_nxt = ST_ZERO;
      end
      ST_SIGN: begin
        cmd.sel  = SEL_SIGN;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = ST_ZERO;
      end
      ST_ZERO: begin
        cmd.sel  = SEL_ZERO;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = ST_X;
      end
      ST_X: begin
        cmd.sel  = SEL_X;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = ST_LEAD;
      end
      ST_LEAD: begin
        cmd.sel  = SEL_LEAD;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = sts.has_point ? ST_POINT : ST_EXP_MARK;
      end
      ST_POINT: begin
        cmd.sel  = SEL_POINT;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) begin
          rem_nxt   = sts.prec;
          fcnt_nxt  = '0;
          state_nxt = (sts.prec != '0) ? ST_FRAC : ST_EXP_MARK;
        end
      end
      ST_FRAC: begin
        cmd.sel  = SEL_FRAC;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) begin
          rem_nxt  = rem_r - PREC_W'(1);
          fcnt_nxt = fcnt_r + 4'd1;
          if (rem_r == PREC_W'(1)) state_nxt = ST_EXP_MARK;
          else if (fcnt_r == 4'(FRAC_NIBBLES - 1)) state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd.sel  = SEL_PAD;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) begin
          rem_nxt = rem_r - PREC_W'(1);
          if (rem_r == PREC_W'(1)) state_nxt = ST_EXP_MARK;
        end
      end
      ST_EXP_MARK: begin
        cmd.sel  = SEL_EXP_MARK;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) state_nxt = ST_EXP_SIGN;
      end
      ST_EXP_SIGN: begin
        cmd.sel  = SEL_EXP_SIGN;
        cmd.emit = sts.emit_ok;
        if (sts.emit_ok) begin
          ecnt_nxt  = sts.ndig;
          state_nxt = ST_EXP_DIGIT;
        end
      end
      ST_EXP_DIGIT: begin
        cmd.sel  = SEL_EXP_DIGIT;
        cmd.emit = sts.emit_ok;
        cmd.last = (ecnt_r == NDIG_W'(1));
        if (sts.emit_ok) begin
          ecnt_nxt = ecnt_r - NDIG_W'(1);
          if (ecnt_r == NDIG_W'(1)) state_nxt = ST_IDLE;
        end
      end
      ST_FAIL: begin
        cmd.sel  = SEL_FAIL;
        cmd.emit = sts.emit_ok;
        cmd.last = 1'b1;
        if (sts.emit_ok) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
      fcnt_r  <= '0;
      ecnt_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      fcnt_r  <= fcnt_nxt;
      ecnt_r  <= ecnt_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

@@ src/hfmt_dp.sv @@
// Datapath: config registers, exponent and precision analysis, rounding,
// decimal exponent digits and the output word register.
module hfmt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hfmt_pkg::dp_cmd_t              cmd,
  output hfmt_pkg::dp_sts_t              sts,
  input  logic [hfmt_pkg::MAG_W-1:0]     in_magnitude_bits,
  input  logic                           in_negative,
  input  logic                           cfg_we,
  input  logic [hfmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfmt_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_character,
  output logic                           out_last,
  output logic                           out_status
);
  import hfmt_pkg::*;

  // configuration
  logic signed [6:0] precision_r;
  logic              upper_r, force_point_r, plus_r, space_r;
  round_mode_t       round_mode_r;
  logic [7:0]        capacity_r;

  // item state
  logic [FRAC_W-1:0] mant_r;
  logic [EXP_W-1:0]  bexp_r;
  logic              neg_r;
  logic [PREC_W-1:0] prec_r;
  logic [1:0]        lead_r;
  logic              eneg_r;
  logic [EXP_W-1:0]  emag_r;
  logic [EXP_W-1:0]  ework_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [NDIG_W-1:0] ndig_r;
  logic [FRAC_W-1:0] frac_r;

  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              out_last_r, out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r   <= -7'sd1;
      upper_r       <= 1'b0;
      force_point_r <= 1'b0;
      plus_r        <= 1'b0;
      space_r       <= 1'b0;
      round_mode_r  <= RM_NEAREST_EVEN;
      capacity_r    <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRECISION:       precision_r   <= cfg_wdata[6:0];
        REG_UPPER_CASE:      upper_r       <= cfg_wdata[0];
        REG_FORCE_POINT:     force_point_r <= cfg_wdata[0];
        REG_PLUS_SIGN:       plus_r        <= cfg_wdata[0];
        REG_SPACE_SIGN:      space_r       <= cfg_wdata[0];
        REG_ROUND_MODE:      round_mode_r  <= round_mode_t'(cfg_wdata[1:0]);
        REG_BUFFER_CAPACITY: capacity_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- analysis: exponent, leading digit, precision
  logic              mant_nz;
  logic [EXP_W-1:0]  emag_a;
  logic              eneg_a;
  logic [PREC_W-1:0] trim_prec, prec_a;

  assign mant_nz = |mant_r;

  always_comb begin
    if (bexp_r == '0) begin
      emag_a = mant_nz ? EXP_W'(SUBN_EXP_MAG) : '0;
      eneg_a = mant_nz;
    end else if (bexp_r >= EXP_W'(EXP_BIAS)) begin
      emag_a = bexp_r - EXP_W'(EXP_BIAS);
      eneg_a = 1'b0;
    end else begin
      emag_a = EXP_W'(EXP_BIAS) - bexp_r;
      eneg_a = 1'b1;
    end
  end

  // shortest exact form: position of the lowest nonzero nibble
  always_comb begin
    trim_prec = '0;
    for (int k = FRAC_NIBBLES - 1; k >= 0; k--) begin
      if (mant_r[4*k +: 4] != 4'd0) trim_prec = PREC_W'(FRAC_NIBBLES - k);
    end
  end

  always_comb begin
    if (precision_r[6]) prec_a = trim_prec;
    else if (precision_r[5:0] > PREC_W'(MAX_PRECISION)) prec_a = PREC_W'(MAX_PRECISION);
    else prec_a = precision_r[5:0];
  end

  // ---- rounding on the left-aligned fraction
  logic [5:0]        shamt;
  logic [FRAC_W:0]   unit;
  logic [FRAC_W-1:0] dropmask, kept_al;
  logic              rbit, sticky, dropped_nz, odd, up, do_round;
  logic [FRAC_W:0]   sum;

  always_comb begin
    shamt      = {4'(FRAC_NIBBLES) - prec_r[3:0], 2'b00};
    unit       = (FRAC_W+1)'(1) << shamt;
    dropmask   = FRAC_W'(unit - (FRAC_W+1)'(1));
    kept_al    = mant_r & ~dropmask;
    rbit       = |(mant_r & FRAC_W'(unit >> 1));
    sticky     = |(mant_r & (dropmask >> 1));
    dropped_nz = |(mant_r & dropmask);
    odd        = (prec_r != '0) ? |(mant_r & unit[FRAC_W-1:0]) : lead_r[0];
    case (round_mode_r)
      RM_TO_ZERO:  up = 1'b0;
      RM_TO_PLUS:  up = !neg_r && dropped_nz;
      RM_TO_MINUS: up = neg_r && dropped_nz;
      default:     up = rbit && (sticky || odd);
    endcase
    sum      = {1'b0, kept_al} + (up ? unit : '0);
    do_round = (prec_r < PREC_W'(FRAC_NIBBLES)) && mant_nz;
  end

  // ---- decimal digit extraction, one digit per step
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [EXP_W-1:0]  qx10;
  logic [3:0]        rdig;
  logic [NDIG_W-1:0] ndig_a;
  logic [4:0]        bcd_sh;

  always_comb begin
    prod   = PROD_W'(ework_r) * PROD_W'(RECIP_10);
    quot   = QUOT_W'(prod >> RECIP_SHIFT);
    qx10   = EXP_W'({quot, 3'b000}) + EXP_W'({quot, 1'b0});
    rdig   = 4'(ework_r - qx10);
    if (emag_r >= EXP_W'(1000)) ndig_a = NDIG_W'(4);
    else if (emag_r >= EXP_W'(100)) ndig_a = NDIG_W'(3);
    else if (emag_r >= EXP_W'(10)) ndig_a = NDIG_W'(2);
    else ndig_a = NDIG_W'(1);
    bcd_sh = {NDIG_W'(DEC_DIGITS) - ndig_r, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mant_r <= in_magnitude_bits[FRAC_W-1:0];
      bexp_r <= in_magnitude_bits[MAG_W-1:FRAC_W];
      neg_r  <= in_negative;
    end
    if (cmd.analyze) begin
      prec_r  <= prec_a;
      lead_r  <= {1'b0, bexp_r != '0};
      eneg_r  <= eneg_a;
      emag_r  <= emag_a;
      ework_r <= emag_a;
    end
    if (cmd.round_en) begin
      ndig_r <= ndig_a;
      if (do_round) begin
        frac_r <= sum[FRAC_W-1:0];
        lead_r <= lead_r + {1'b0, sum[FRAC_W]};
      end else begin
        frac_r <= mant_r;
      end
    end else if (cmd.emit && cmd.sel == SEL_FRAC) begin
      frac_r <= frac_r << 4;
    end
    if (cmd.digit_step) begin
      ework_r <= EXP_W'(quot);
      bcd_r   <= {rdig, bcd_r[BCD_W-1:4]};
    end else if (cmd.check) begin
      bcd_r <= bcd_r << bcd_sh;
    end else if (cmd.emit && cmd.sel == SEL_EXP_DIGIT) begin
      bcd_r <= bcd_r << 4;
    end
  end

  // ---- text length and status
  logic [LEN_W-1:0] len;
  logic             has_sign, has_point;

  assign has_sign  = neg_r | plus_r | space_r;
  assign has_point = (prec_r != '0) | force_point_r;
  assign len = LEN_W'(has_sign) + LEN_W'(has_point) + LEN_W'(prec_r) + LEN_W'(ndig_r)
             + LEN_W'(5);

  always_comb begin
    sts.emit_ok   = !out_valid_r || out_ready;
    sts.has_sign  = has_sign;
    sts.has_point = has_point;
    sts.prec      = prec_r;
    sts.ndig      = ndig_r;
    sts.too_small = 8'(len) >= capacity_r;
  end

  // ---- output word register
  logic [7:0] char_a;

  always_comb begin
    case (cmd.sel)
      SEL_SIGN:      char_a = neg_r ? ASC_MINUS : (plus_r ? ASC_PLUS : ASC_SPACE);
      SEL_ZERO:      char_a = ASC_ZERO;
      SEL_X:         char_a = upper_r ? ASC_UPPER_X : ASC_LOWER_X;
      SEL_LEAD:      char_a = hex_char({2'b00, lead_r}, upper_r);
      SEL_POINT:     char_a = ASC_POINT;
      SEL_FRAC:      char_a = hex_char(frac_r[FRAC_W-1 -: 4], upper_r);
      SEL_PAD:       char_a = ASC_ZERO;
      SEL_EXP_MARK:  char_a = upper_r ? ASC_UPPER_P : ASC_LOWER_P;
      SEL_EXP_SIGN:  char_a = eneg_r ? ASC_MINUS : ASC_PLUS;
      SEL_EXP_DIGIT: char_a = hex_char(bcd_r[BCD_W-1 -: 4], upper_r);
      SEL_FAIL:      char_a = ASC_NUL;
      default:       char_a = ASC_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r   <= char_a;
      out_last_r   <= cmd.last;
      out_status_r <= (cmd.sel == SEL_FAIL);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

endmodule

@@ src/hex_float_text_formatter_unit.sv @@
// Hex float text formatter: one binary64 magnitude and sign in, its %a text out
// one character per word. The item is captured, then analyzed (exponent,
// precision), rounded, and its decimal exponent split into four digits, one per
// cycle, before the text goes out one character a cycle through an output
// register while the receiver does not stall. One item is in work at a time; a
// new item is taken as soon as the last character sits in the output register.
// If the text length reaches the buffer capacity a single word with character 0,
// last 1 and status 1 is sent instead. Configuration is written through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce.
module hex_float_text_formatter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  hfmt_in_if.sink                        in_chan,
  hfmt_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [hfmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfmt_pkg::CFG_W-1:0]     cfg_wdata
);
  import hfmt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hfmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hfmt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_magnitude_bits (in_chan.magnitude_bits),
    .in_negative       (in_chan.negative),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_character     (out_chan.character),
    .out_last          (out_chan.last),
    .out_status        (out_chan.status)
  );

endmodule
